### sv/csc_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and types for the compressed sparse column matrix block.
// Depends on nothing; imported by csc_colfind and csc_sparse_matrix_access.

package csc_pkg;

  // storage limits
  localparam int MAX_DIM      = 64;
  localparam int MAX_NONZEROS = 4096;

  // field and register widths
  localparam int FUNC_W    = 3;
  localparam int SLOT_W    = 12;
  localparam int PTR_W     = 13;
  localparam int ROW_W     = 6;
  localparam int VAL_W     = 32;
  localparam int OUT_W     = 48;
  localparam int DIM_CFG_W = 7;
  localparam int NNZ_CFG_W = 13;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;

  // derived widths
  localparam int DIM_W = $clog2(MAX_DIM + 1);       // holds 0..MAX_DIM, also pointer address
  localparam int COL_W = $clog2(MAX_DIM);           // column / row index
  localparam int NNZ_W = $clog2(MAX_NONZEROS + 1);  // holds 0..MAX_NONZEROS
  localparam int EA_W  = $clog2(MAX_NONZEROS);      // entry address
  localparam int CMP_W = (PTR_W > EA_W) ? PTR_W : EA_W;

  // request function codes
  localparam logic [FUNC_W-1:0] FN_LOAD_PTR = 3'd0;
  localparam logic [FUNC_W-1:0] FN_LOAD_NZ  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_DENSE    = 3'd2;
  localparam logic [FUNC_W-1:0] FN_LOCATE   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_SUMS     = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DIM = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NNZ = 1'b1;

  // column pointer write port
  typedef struct packed {
    logic             we;
    logic [DIM_W-1:0] addr;
    logic [PTR_W-1:0] data;
  } cs_wr_t;

  // column search start
  typedef struct packed {
    logic            start;
    logic [EA_W-1:0] idx;
  } cf_req_t;

  // column search answer, done is a one-cycle pulse, found/col hold until next start
  typedef struct packed {
    logic             done;
    logic             found;
    logic [COL_W-1:0] col;
  } cf_rsp_t;

endpackage

### sv/csc_sparse_matrix_access.sv
`timescale 1ns / 1ps
// Compressed sparse column matrix store: loads, dense-row, locate and row-sum requests.
// Depends on csc_pkg and csc_colfind.

// One request is worked on at a time; loads give no result. A dense-row request
// walks the stored nonzeros through the entry memory, plus a column search for
// each entry in the asked row, then emits one result per column. A row-sum request
// reads each nonzero entry, then the accumulator of its row, then writes it back,
// and then emits one result per row. A locate request waits on the column pointer
// search. An out-of-range row or k, or a locate whose entry is in no column, gives
// an error result. Results wait in an output register, so the next request is
// taken while the last result of the previous one is still stalled. Sums cannot
// overflow 48 bits at these depths, so no clamp is needed.

module csc_sparse_matrix_access
  import csc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  // request channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [FUNC_W-1:0]    in_func,
  input  logic [SLOT_W-1:0]    in_slot,
  input  logic [PTR_W-1:0]     in_pointer_value,
  input  logic [ROW_W-1:0]     in_row_number,
  input  logic [VAL_W-1:0]     in_entry_value,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [OUT_W-1:0]     out_value,
  output logic [ROW_W-1:0]     out_row,
  output logic [ROW_W-1:0]     out_col,
  output logic                 out_error,
  output logic                 out_last
);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_ERR     = 4'd1;
  localparam logic [3:0] ST_DR_RD   = 4'd2;
  localparam logic [3:0] ST_DR_CHK  = 4'd3;
  localparam logic [3:0] ST_DR_FIND = 4'd4;
  localparam logic [3:0] ST_RS_RD   = 4'd5;
  localparam logic [3:0] ST_RS_ROW  = 4'd6;
  localparam logic [3:0] ST_RS_ACC  = 4'd7;
  localparam logic [3:0] ST_EM_RD   = 4'd8;
  localparam logic [3:0] ST_EM_OUT  = 4'd9;
  localparam logic [3:0] ST_LC_WAIT = 4'd10;
  localparam logic [3:0] ST_LC_OUT  = 4'd11;

  // configuration
  logic [DIM_CFG_W-1:0] dim_cfg_r;
  logic [NNZ_CFG_W-1:0] nnz_cfg_r;
  logic [DIM_W-1:0]     dim_eff;
  logic [NNZ_W-1:0]     nnz_eff;

  // control
  logic [3:0]       state_r, state_nxt;
  logic [NNZ_W-1:0] i_r, i_nxt;
  logic [DIM_W-1:0] j_r, j_nxt;
  logic [ROW_W-1:0] q_row_r, q_row_nxt;
  logic [VAL_W-1:0] q_val_r, q_val_nxt;
  logic             q_sum_r, q_sum_nxt;
  logic [COL_W-1:0] acc_row_r, acc_row_nxt;
  logic             scan_done;
  logic             em_last;

  // entry memory: row index above value
  logic [ROW_W+VAL_W-1:0] ent_mem [0:MAX_NONZEROS-1];
  logic [ROW_W+VAL_W-1:0] ent_rdata_r;
  logic                   ent_we;
  logic [EA_W-1:0]        ent_waddr;
  logic [ROW_W+VAL_W-1:0] ent_wdata;
  logic                   ent_re;
  logic [EA_W-1:0]        ent_raddr;
  logic [ROW_W-1:0]       ent_row;
  logic [VAL_W-1:0]       ent_val;

  // per-column line / per-row sum scratch memory
  logic [OUT_W-1:0]   work_mem [0:MAX_DIM-1];
  logic [OUT_W-1:0]   work_rdata_r;
  logic [MAX_DIM-1:0] work_valid_r;
  logic               work_re;
  logic [COL_W-1:0]   work_raddr;
  logic               work_we;
  logic [COL_W-1:0]   work_waddr;
  logic [OUT_W-1:0]   work_wdata;
  logic               valid_clr;
  logic [OUT_W-1:0]   val_ext;
  logic [OUT_W-1:0]   acc_base;
  logic [OUT_W-1:0]   em_value;

  // column search
  cs_wr_t  cs_wr;
  cf_req_t cf_req;
  cf_rsp_t cf_rsp;

  // output register
  logic             out_valid_r;
  logic [OUT_W-1:0] out_value_r;
  logic [ROW_W-1:0] out_row_r;
  logic [ROW_W-1:0] out_col_r;
  logic             out_error_r;
  logic             out_last_r;
  logic             out_free;
  logic             out_load;
  logic [OUT_W-1:0] res_value;
  logic [ROW_W-1:0] res_row;
  logic [ROW_W-1:0] res_col;
  logic             res_error;
  logic             res_last;

  csc_colfind u_colfind (
    .clk   (clk),
    .rst_n (rst_n),
    .cs_wr (cs_wr),
    .dim   (dim_eff),
    .req   (cf_req),
    .rsp   (cf_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_cfg_r <= DIM_CFG_W'(1);
      nnz_cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DIM: dim_cfg_r <= cfg_wdata[DIM_CFG_W-1:0];
        CFG_NNZ: nnz_cfg_r <= cfg_wdata[NNZ_CFG_W-1:0];
      endcase
    end
  end

  always_comb begin
    if (dim_cfg_r == '0) begin
      dim_eff = DIM_W'(1);
    end else if (int'(dim_cfg_r) > MAX_DIM) begin
      dim_eff = DIM_W'(MAX_DIM);
    end else begin
      dim_eff = DIM_W'(dim_cfg_r);
    end
    if (int'(nnz_cfg_r) > MAX_NONZEROS) begin
      nnz_eff = NNZ_W'(MAX_NONZEROS);
    end else begin
      nnz_eff = NNZ_W'(nnz_cfg_r);
    end
  end

  assign ent_row   = ent_rdata_r[VAL_W +: ROW_W];
  assign ent_val   = ent_rdata_r[VAL_W-1:0];
  assign val_ext   = {{(OUT_W-VAL_W){q_val_r[VAL_W-1]}}, q_val_r};
  assign acc_base  = work_valid_r[acc_row_r] ? work_rdata_r : '0;
  assign em_value  = work_valid_r[j_r[COL_W-1:0]] ? work_rdata_r : '0;
  assign scan_done = (NNZ_W'(i_r + 1'b1) == nnz_eff);
  assign em_last   = (DIM_W'(j_r + 1'b1) == dim_eff);
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);

  always_comb begin
    state_nxt   = state_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    q_row_nxt   = q_row_r;
    q_val_nxt   = q_val_r;
    q_sum_nxt   = q_sum_r;
    acc_row_nxt = acc_row_r;

    ent_we    = 1'b0;
    ent_waddr = EA_W'(in_slot);
    ent_wdata = {in_row_number, in_entry_value};
    ent_re    = 1'b0;
    ent_raddr = i_r[EA_W-1:0];

    cs_wr.we   = 1'b0;
    cs_wr.addr = DIM_W'(in_slot);
    cs_wr.data = in_pointer_value;

    cf_req.start = 1'b0;
    cf_req.idx   = i_r[EA_W-1:0];

    work_re    = 1'b0;
    work_raddr = j_r[COL_W-1:0];
    work_we    = 1'b0;
    work_waddr = acc_row_r;
    work_wdata = acc_base + val_ext;
    valid_clr  = 1'b0;

    out_load  = 1'b0;
    res_value = '0;
    res_row   = '0;
    res_col   = '0;
    res_error = 1'b0;
    res_last  = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          i_nxt     = '0;
          j_nxt     = '0;
          q_row_nxt = in_row_number;
          case (in_func)
            FN_LOAD_PTR: begin
              cs_wr.we = (int'(in_slot) <= MAX_DIM);
            end
            FN_LOAD_NZ: begin
              ent_we = (int'(in_slot) < MAX_NONZEROS);
            end
            FN_DENSE: begin
              q_sum_nxt = 1'b0;
              valid_clr = 1'b1;
              if (int'(in_row_number) >= int'(dim_eff)) begin
                state_nxt = ST_ERR;
              end else if (nnz_eff == '0) begin
                state_nxt = ST_EM_RD;
              end else begin
                state_nxt = ST_DR_RD;
              end
            end
            FN_LOCATE: begin
              if (int'(in_slot) >= int'(nnz_eff)) begin
                state_nxt = ST_ERR;
              end else begin
                ent_re       = 1'b1;
                ent_raddr    = EA_W'(in_slot);
                cf_req.start = 1'b1;
                cf_req.idx   = EA_W'(in_slot);
                state_nxt    = ST_LC_WAIT;
              end
            end
            FN_SUMS: begin
              q_sum_nxt = 1'b1;
              valid_clr = 1'b1;
              state_nxt = (nnz_eff == '0) ? ST_EM_RD : ST_RS_RD;
            end
            default: begin
              // unused codes are dropped
            end
          endcase
        end
      end

      ST_ERR: begin
        if (out_free) begin
          out_load  = 1'b1;
          res_error = 1'b1;
          res_last  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      ST_DR_RD: begin
        ent_re    = 1'b1;
        state_nxt = ST_DR_CHK;
      end

      ST_DR_CHK: begin
        if (ent_row == q_row_r) begin
          cf_req.start = 1'b1;
          q_val_nxt    = ent_val;
          state_nxt    = ST_DR_FIND;
        end else if (scan_done) begin
          state_nxt = ST_EM_RD;
        end else begin
          i_nxt     = NNZ_W'(i_r + 1'b1);
          state_nxt = ST_DR_RD;
        end
      end

      ST_DR_FIND: begin
        if (cf_rsp.done) begin
          // entries in no column are skipped; later entries overwrite earlier ones
          if (cf_rsp.found) begin
            work_we    = 1'b1;
            work_waddr = cf_rsp.col;
            work_wdata = val_ext;
          end
          if (scan_done) begin
            state_nxt = ST_EM_RD;
          end else begin
            i_nxt     = NNZ_W'(i_r + 1'b1);
            state_nxt = ST_DR_RD;
          end
        end
      end

      ST_RS_RD: begin
        ent_re    = 1'b1;
        state_nxt = ST_RS_ROW;
      end

      ST_RS_ROW: begin
        if (int'(ent_row) < int'(dim_eff)) begin
          work_re     = 1'b1;
          work_raddr  = ent_row[COL_W-1:0];
          acc_row_nxt = ent_row[COL_W-1:0];
          q_val_nxt   = ent_val;
          state_nxt   = ST_RS_ACC;
        end else if (scan_done) begin
          state_nxt = ST_EM_RD;
        end else begin
          i_nxt     = NNZ_W'(i_r + 1'b1);
          state_nxt = ST_RS_RD;
        end
      end

      ST_RS_ACC: begin
        // read-modify-write of one row sum, written back before the next row is read
        work_we = 1'b1;
        if (scan_done) begin
          state_nxt = ST_EM_RD;
        end else begin
          i_nxt     = NNZ_W'(i_r + 1'b1);
          state_nxt = ST_RS_RD;
        end
      end

      ST_EM_RD: begin
        work_re   = 1'b1;
        state_nxt = ST_EM_OUT;
      end

      ST_EM_OUT: begin
        if (out_free) begin
          out_load  = 1'b1;
          res_value = em_value;
          res_row   = q_sum_r ? ROW_W'(j_r) : q_row_r;
          res_col   = q_sum_r ? '0 : ROW_W'(j_r);
          res_last  = em_last;
          if (em_last) begin
            state_nxt = ST_IDLE;
          end else begin
            j_nxt     = DIM_W'(j_r + 1'b1);
            state_nxt = ST_EM_RD;
          end
        end
      end

      ST_LC_WAIT: begin
        if (cf_rsp.done) begin
          state_nxt = cf_rsp.found ? ST_LC_OUT : ST_ERR;
        end
      end

      ST_LC_OUT: begin
        if (out_free) begin
          out_load  = 1'b1;
          res_row   = ent_row;
          res_col   = ROW_W'(cf_rsp.col);
          res_last  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    q_row_r   <= q_row_nxt;
    q_val_r   <= q_val_nxt;
    q_sum_r   <= q_sum_nxt;
    acc_row_r <= acc_row_nxt;
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    if (ent_re) begin
      ent_rdata_r <= ent_mem[ent_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (work_we) begin
      work_mem[work_waddr] <= work_wdata;
    end
    if (work_re) begin
      work_rdata_r <= work_mem[work_raddr];
    end
  end

  // rows or columns never written in this request read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_valid_r <= '0;
    end else if (valid_clr) begin
      work_valid_r <= '0;
    end else if (work_we) begin
      work_valid_r[work_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r <= res_value;
      out_row_r   <= res_row;
      out_col_r   <= res_col;
      out_error_r <= res_error;
      out_last_r  <= res_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_error = out_error_r;
  assign out_last  = out_last_r;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || !out_stall))
    else $error("result loaded over a pending result");

  a_search_owner: assert property (@(posedge clk) disable iff (!rst_n)
    cf_rsp.done |-> (state_r == ST_DR_FIND || state_r == ST_LC_WAIT))
    else $error("column search answered with no request waiting");

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && res_last) |=> (state_r == ST_IDLE))
    else $error("final result did not end the request");

  a_work_in_dim: assert property (@(posedge clk) disable iff (!rst_n)
    work_we |-> (int'(work_waddr) < int'(dim_eff)))
    else $error("scratch write outside the matrix dimension");
`endif

endmodule

### sv/csc_colfind.sv
`timescale 1ns / 1ps
// Column pointer store and search: finds the first column whose range holds an entry index.
// Depends on csc_pkg.

module csc_colfind
  import csc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cs_wr_t           cs_wr,
  input  logic [DIM_W-1:0] dim,
  input  cf_req_t          req,
  output cf_rsp_t          rsp
);

  logic [PTR_W-1:0] cs_mem [0:MAX_DIM];
  logic [PTR_W-1:0] rd_lo_r;
  logic [PTR_W-1:0] rd_hi_r;

  logic             active_r, active_nxt;
  logic [DIM_W-1:0] j_r, j_nxt;
  logic             chk_r, chk_nxt;
  logic [DIM_W-1:0] jd_r, jd_nxt;
  logic [EA_W-1:0]  idx_r, idx_nxt;
  logic             done_r, done_nxt;
  logic             found_r, found_nxt;
  logic [COL_W-1:0] col_r, col_nxt;

  logic issue;
  logic hit;
  logic last_chk;

  // both ends of the range for column j are read together
  always_ff @(posedge clk) begin
    if (cs_wr.we) begin
      cs_mem[cs_wr.addr] <= cs_wr.data;
    end
    if (issue) begin
      rd_lo_r <= cs_mem[j_r];
      rd_hi_r <= cs_mem[DIM_W'(j_r + 1'b1)];
    end
  end

  assign issue    = active_r && (j_r < dim);
  assign hit      = chk_r && (CMP_W'(rd_lo_r) <= CMP_W'(idx_r))
                          && (CMP_W'(rd_hi_r) > CMP_W'(idx_r));
  assign last_chk = chk_r && (DIM_W'(jd_r + 1'b1) == dim);

  always_comb begin
    active_nxt = active_r;
    j_nxt      = j_r;
    chk_nxt    = chk_r;
    jd_nxt     = jd_r;
    idx_nxt    = idx_r;
    done_nxt   = 1'b0;
    found_nxt  = found_r;
    col_nxt    = col_r;
    if (req.start) begin
      active_nxt = 1'b1;
      j_nxt      = '0;
      chk_nxt    = 1'b0;
      idx_nxt    = req.idx;
      found_nxt  = 1'b0;
    end else if (active_r) begin
      // read of column j overlaps the compare of column j-1
      chk_nxt = issue;
      jd_nxt  = j_r;
      if (issue) begin
        j_nxt = DIM_W'(j_r + 1'b1);
      end
      if (hit) begin
        active_nxt = 1'b0;
        chk_nxt    = 1'b0;
        done_nxt   = 1'b1;
        found_nxt  = 1'b1;
        col_nxt    = jd_r[COL_W-1:0];
      end else if (last_chk) begin
        active_nxt = 1'b0;
        chk_nxt    = 1'b0;
        done_nxt   = 1'b1;
        found_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      chk_r    <= 1'b0;
      done_r   <= 1'b0;
      found_r  <= 1'b0;
    end else begin
      active_r <= active_nxt;
      chk_r    <= chk_nxt;
      done_r   <= done_nxt;
      found_r  <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    j_r   <= j_nxt;
    jd_r  <= jd_nxt;
    idx_r <= idx_nxt;
    col_r <= col_nxt;
  end

  assign rsp.done  = done_r;
  assign rsp.found = found_r;
  assign rsp.col   = col_r;

endmodule
